// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Shared constants, command codes and record types for the time-slice
// scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [15:0] MIN_SLICE = 16'd1;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] tick_value;
        logic [15:0] slice_ticks;
        logic [3:0]  task_index;
    } t_cmd;

    typedef struct packed {
        logic [15:0] slice;
        logic [15:0] remain;
        logic [63:0] run_ticks;
        logic [63:0] switch_ins;
        logic        running;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Entry 0 after reset: the idle task, one-tick slice, running.
    localparam t_entry ENTRY0_RST = '{
        slice:      16'd1,
        remain:     16'd1,
        run_ticks:  64'd0,
        switch_ins: 64'd0,
        running:    1'b1
    };

    typedef struct packed {
        logic        accepted;
        logic [3:0]  current_task;
        logic [4:0]  tasks_loaded;
        logic        switched;
        logic [63:0] context_switches;
        logic [63:0] last_tick;
        logic [15:0] entry_slice;
        logic [15:0] entry_remaining;
        logic [63:0] entry_run_ticks;
        logic [63:0] entry_switch_ins;
        logic        entry_running;
    } t_result;

endpackage

// ----- rtl/rrts_in_if.sv -----
// ----------------------------------------------------------------------------
// Scheduler command channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface rrts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] tick_value;
    logic [15:0] slice_ticks;
    logic [3:0]  task_index;

    modport source (
        output valid, mode, tick_value, slice_ticks, task_index,
        input  ready
    );

    modport sink (
        input  valid, mode, tick_value, slice_ticks, task_index,
        output ready
    );
endinterface

// ----- rtl/rrts_out_if.sv -----
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface rrts_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  current_task;
    logic [4:0]  tasks_loaded;
    logic        switched;
    logic [63:0] context_switches;
    logic [63:0] last_tick;
    logic [15:0] entry_slice;
    logic [15:0] entry_remaining;
    logic [63:0] entry_run_ticks;
    logic [63:0] entry_switch_ins;
    logic        entry_running;

    modport source (
        output valid, accepted, current_task, tasks_loaded, switched,
               context_switches, last_tick, entry_slice, entry_remaining,
               entry_run_ticks, entry_switch_ins, entry_running,
        input  ready
    );

    modport sink (
        input  valid, accepted, current_task, tasks_loaded, switched,
               context_switches, last_tick, entry_slice, entry_remaining,
               entry_run_ticks, entry_switch_ins, entry_running,
        output ready
    );
endinterface

// ----- rtl/round_robin_time_slice_scheduler.sv -----
// Result path: an add, an out-of-range read or an unused mode is answered
// from the idle state; a read or a same-task tick from the fetch state; a
// tick that switches tasks from the next-task state; then the result register.
// One command is in flight at a time; the table RAM's registered read sets
// these steps, and a new command is taken once the result register frees.
// Reset is synchronous, with no table clearing pass.
// ----------------------------------------------------------------------------
// Round-robin time-slice scheduler
// Task table in RAM with a sequencer that adds tasks, charges ticks, rotates
// the running task and serves entry reads, followed by a result register.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrts_in_if.sink    i_cmd,
    rrts_out_if.source o_res
);
    import rrts_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);

    t_cmd             cmd;
    t_result          seq_res;
    logic             seq_res_valid;
    logic             cmd_ready;
    logic             res_free;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    logic             r_out_valid;
    t_result          r_out;

    assign cmd.mode        = i_cmd.mode;
    assign cmd.tick_value  = i_cmd.tick_value;
    assign cmd.slice_ticks = i_cmd.slice_ticks;
    assign cmd.task_index  = i_cmd.task_index;
    assign i_cmd.ready     = cmd_ready;

    assign res_free = !r_out_valid || o_res.ready;

    rrts_seq #(
        .MAX_TASKS (MAX_TASKS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_res_free  (res_free),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    rrts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.accepted         = r_out.accepted;
    assign o_res.current_task     = r_out.current_task;
    assign o_res.tasks_loaded     = r_out.tasks_loaded;
    assign o_res.switched         = r_out.switched;
    assign o_res.context_switches = r_out.context_switches;
    assign o_res.last_tick        = r_out.last_tick;
    assign o_res.entry_slice      = r_out.entry_slice;
    assign o_res.entry_remaining  = r_out.entry_remaining;
    assign o_res.entry_run_ticks  = r_out.entry_run_ticks;
    assign o_res.entry_switch_ins = r_out.entry_switch_ins;
    assign o_res.entry_running    = r_out.entry_running;
endmodule

// ----- rtl/rrts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rrts_seq.sv -----
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Adds entries; serves reads; a tick reads, updates and writes back the
// running task's entry, walking to the next task in the ring on expiry.
// ----------------------------------------------------------------------------
module rrts_seq #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  rrts_pkg::t_cmd               i_cmd,
    input  logic                         i_res_free,
    output logic                         o_res_valid,
    output rrts_pkg::t_result            o_res,
    output logic                         o_ram_we,
    output logic [$clog2(MAX_TASKS)-1:0] o_ram_waddr,
    output rrts_pkg::t_entry             o_ram_wdata,
    output logic [$clog2(MAX_TASKS)-1:0] o_ram_raddr,
    input  rrts_pkg::t_entry             i_ram_rdata
);
    import rrts_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_NEXT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_num, n_num;
    logic [63:0]      r_last, n_last;
    logic [63:0]      r_total, n_total;
    logic [1:0]       r_mode, n_mode;
    logic [IDX_W-1:0] r_rd_addr;
    logic             r_e0_vld;

    t_entry           rd_ent;
    t_entry           e_out;
    logic             acc;
    logic             sw;
    logic [15:0]      add_slice;
    logic [CMP_W-1:0] idx_ext;
    logic             idx_ok;
    logic [15:0]      rem_dec;
    logic             expired;
    logic [CNT_W-1:0] nxt_ext;
    logic [IDX_W-1:0] nxt;
    logic             do_switch;
    logic [CMP_W-1:0] cur_out;
    logic [CMP_W-1:0] num_out;

    // Entry 0 holds its reset contents until the first write-back reaches it.
    assign rd_ent = (r_rd_addr == '0 && !r_e0_vld) ? ENTRY0_RST : i_ram_rdata;

    assign o_cmd_ready = (r_state == ST_IDLE) && i_res_free;

    assign add_slice = (i_cmd.slice_ticks < MIN_SLICE) ? MIN_SLICE : i_cmd.slice_ticks;
    assign idx_ext   = CMP_W'(i_cmd.task_index);
    assign idx_ok    = idx_ext < CMP_W'(r_num);

    assign rem_dec   = (rd_ent.remain != 16'd0) ? (rd_ent.remain - 16'd1) : 16'd0;
    assign expired   = (rem_dec == 16'd0);
    assign nxt_ext   = CNT_W'(r_cur) + CNT_W'(1);
    assign nxt       = (nxt_ext >= r_num) ? '0 : nxt_ext[IDX_W-1:0];
    assign do_switch = expired && (nxt != r_cur);

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_num       = r_num;
        n_last      = r_last;
        n_total     = r_total;
        n_mode      = r_mode;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_cur;
        o_ram_wdata = rd_ent;
        o_ram_raddr = r_rd_addr;
        o_res_valid = 1'b0;
        acc         = 1'b0;
        sw          = 1'b0;
        e_out       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_mode = i_cmd.mode;
                    case (i_cmd.mode)
                        MODE_TICK: begin
                            n_last      = i_cmd.tick_value;
                            o_ram_raddr = r_cur;
                            n_state     = ST_FETCH;
                        end
                        MODE_ADD: begin
                            o_res_valid = 1'b1;
                            if (r_num < CNT_MAX) begin
                                acc         = 1'b1;
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_num[IDX_W-1:0];
                                o_ram_wdata = '{
                                    slice:      add_slice,
                                    remain:     add_slice,
                                    run_ticks:  64'd0,
                                    switch_ins: 64'd0,
                                    running:    1'b0
                                };
                                n_num       = r_num + CNT_W'(1);
                            end
                        end
                        MODE_READ: begin
                            if (idx_ok) begin
                                o_ram_raddr = idx_ext[IDX_W-1:0];
                                n_state     = ST_FETCH;
                            end else begin
                                o_res_valid = 1'b1;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                if (r_mode == MODE_READ) begin
                    o_res_valid = 1'b1;
                    acc         = 1'b1;
                    e_out       = rd_ent;
                    n_state     = ST_IDLE;
                end else begin
                    // Charge the running task and reload its slice when it expires.
                    o_ram_we              = 1'b1;
                    o_ram_waddr           = r_cur;
                    o_ram_wdata.remain    = expired ? rd_ent.slice : rem_dec;
                    o_ram_wdata.run_ticks = rd_ent.run_ticks + 64'd1;
                    o_ram_wdata.running   = rd_ent.running & ~do_switch;
                    if (do_switch) begin
                        o_ram_raddr = nxt;
                        n_state     = ST_NEXT;
                    end else begin
                        o_res_valid = 1'b1;
                        acc         = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_NEXT: begin
                o_ram_we               = 1'b1;
                o_ram_waddr            = r_rd_addr;
                o_ram_wdata.remain     = rd_ent.slice;
                o_ram_wdata.switch_ins = rd_ent.switch_ins + 64'd1;
                o_ram_wdata.running    = 1'b1;
                n_cur                  = r_rd_addr;
                n_total                = r_total + 64'd1;
                o_res_valid            = 1'b1;
                acc                    = 1'b1;
                sw                     = 1'b1;
                n_state                = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign cur_out = CMP_W'(n_cur);
    assign num_out = CMP_W'(n_num);

    always_comb begin
        o_res.accepted         = acc;
        o_res.current_task     = cur_out[3:0];
        o_res.tasks_loaded     = num_out[4:0];
        o_res.switched         = sw;
        o_res.context_switches = n_total;
        o_res.last_tick        = n_last;
        o_res.entry_slice      = e_out.slice;
        o_res.entry_remaining  = e_out.remain;
        o_res.entry_run_ticks  = e_out.run_ticks;
        o_res.entry_switch_ins = e_out.switch_ins;
        o_res.entry_running    = e_out.running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_num    <= CNT_W'(1);
            r_last   <= '0;
            r_total  <= '0;
            r_mode   <= MODE_TICK;
            r_e0_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_num   <= n_num;
            r_last  <= n_last;
            r_total <= n_total;
            r_mode  <= n_mode;
            if (o_ram_we && o_ram_waddr == '0) begin
                r_e0_vld <= 1'b1;
            end
        end
    end

    // Tracks the address behind the RAM's registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= o_ram_raddr;
    end
endmodule

// ----- rtl/rrts_chk.sv -----
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the scheduler's channels for ordering and result consistency.
// ----------------------------------------------------------------------------
module rrts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_accepted,
    input logic        i_out_switched,
    input logic [4:0]  i_out_tasks_loaded,
    input logic [63:0] i_out_context_switches,
    input logic [15:0] i_out_entry_slice,
    input logic [15:0] i_out_entry_remaining,
    input logic [63:0] i_out_entry_run_ticks,
    input logic [63:0] i_out_entry_switch_ins,
    input logic        i_out_entry_running
);
    logic r_pend;
    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Set while a command word has been taken and its result word has not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (in_acc) begin
            r_pend <= 1'b1;
        end else if (out_acc) begin
            r_pend <= 1'b0;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_accepted)
            && $stable(i_out_switched) && $stable(i_out_context_switches)
            && $stable(i_out_entry_run_ticks))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_pend || out_acc)
        else $error("command taken before previous result was delivered");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_accepted |-> !i_out_switched
            && i_out_entry_slice == 16'd0 && i_out_entry_remaining == 16'd0
            && i_out_entry_run_ticks == 64'd0 && i_out_entry_switch_ins == 64'd0
            && !i_out_entry_running)
        else $error("refused command returned entry data");

    a_switch_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_switched |-> i_out_accepted
            && i_out_tasks_loaded > 5'd1 && i_out_entry_slice == 16'd0)
        else $error("task switch reported with fewer than two tasks");
endmodule

bind round_robin_time_slice_scheduler rrts_chk u_rrts_chk (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_in_valid             (i_cmd.valid),
    .i_in_ready             (i_cmd.ready),
    .i_out_valid            (o_res.valid),
    .i_out_ready            (o_res.ready),
    .i_out_accepted         (o_res.accepted),
    .i_out_switched         (o_res.switched),
    .i_out_tasks_loaded     (o_res.tasks_loaded),
    .i_out_context_switches (o_res.context_switches),
    .i_out_entry_slice      (o_res.entry_slice),
    .i_out_entry_remaining  (o_res.entry_remaining),
    .i_out_entry_run_ticks  (o_res.entry_run_ticks),
    .i_out_entry_switch_ins (o_res.entry_switch_ins),
    .i_out_entry_running    (o_res.entry_running)
);
